FILE: hdl/hss_pkg.sv
// ---------------------------------------------------------------------------
// hss_pkg: shared types and constants of the heat stencil step
// Grid limits, fixed-point formats, config register codes and the word
// that travels from the window front end to the arithmetic back end.
// ---------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int DATA_WIDTH = 32;

  // line buffer depth: interior columns plus two ghost columns
  localparam int LINE_DEPTH = MAX_COLS + 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // counters reach cols+1 and rows+1
  localparam int COL_W = $clog2(MAX_COLS + 2);
  localparam int ROW_W = $clog2(MAX_ROWS + 2);

  // field and register widths fixed by the interface
  localparam int OUT_ROW_W   = 12;
  localparam int OUT_COL_W   = 10;
  localparam int CFG_COLS_W  = 11;
  localparam int CFG_ROWS_W  = 13;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(1024);
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(4096);
  localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(13107);

  // arithmetic: laplacian, gain product (Q.46), rounded sum
  localparam int LAP_W       = DATA_WIDTH + 3;
  localparam int PROD_W      = LAP_W + GAIN_W + 1;
  localparam int FRAC_SHIFT  = GAIN_W;
  localparam int ROUND_BIAS  = 1 << (FRAC_SHIFT - 1);
  localparam int SUM_W       = PROD_W - FRAC_SHIFT + 1;

  // decoupling queue, depth a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_GAIN = 2'd2
  } cfg_idx_e;

  // frame geometry seen by the front end
  typedef struct packed {
    logic [COL_W-1:0] cols_lim;  // last raster column index (cols+1)
    logic [ROW_W-1:0] rows_lim;  // last raster row index (rows+1)
    logic             restart;
  } frame_cfg_t;

  // one stencil, ready for the arithmetic
  typedef struct packed {
    data_t                up;
    data_t                ctr;
    data_t                dn;
    data_t                left;
    data_t                right;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } stencil_word_t;

endpackage

`default_nettype wire

FILE: hdl/hss_front.sv
// ---------------------------------------------------------------------------
// hss_front: raster counters, line buffers and 3x3 window
// Accepts one sample per cycle while the queue is not full, reads both line buffers at the column,
// shifts the window and hands complete stencils to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module hss_front import hss_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire frame_cfg_t    frame_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire data_t         sample_i,
  input  wire logic          fifo_full_i,
  output logic               push_o,
  output stencil_word_t      push_word_o
);

  data_t upper_line [LINE_DEPTH];
  data_t middle_line [LINE_DEPTH];

  logic [COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;

  // stage A: accepted sample plus its line buffer reads
  logic                 a_valid_q;
  data_t                a_sample_q;
  logic [LINE_AW-1:0]   a_x_q;
  logic                 a_prod_q;
  logic [OUT_ROW_W-1:0] a_row_q;
  logic [OUT_COL_W-1:0] a_col_q;
  logic                 a_last_q;
  data_t                top_q;
  data_t                mid_q;

  data_t win_up_q, win_ctr_q, win_dn_q, win_left_q;

  logic             accept;
  logic             a_adv;
  logic             prod_d;
  logic             last_d;
  logic [ROW_W-1:0] row_off;
  logic [COL_W-1:0] col_off;

  assign a_adv      = a_valid_q && (!a_prod_q || !fifo_full_i);
  assign in_stall_o = a_valid_q && !a_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    prod_d  = (row_cnt_q >= ROW_W'(2)) && (col_cnt_q >= COL_W'(2));
    last_d  = (row_cnt_q == frame_i.rows_lim) && (col_cnt_q == frame_i.cols_lim);
    row_off = row_cnt_q - ROW_W'(2);
    col_off = col_cnt_q - COL_W'(2);
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (frame_i.restart) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (accept) begin
      if (col_cnt_q >= frame_i.cols_lim) begin
        col_cnt_d = '0;
        row_cnt_d = (row_cnt_q >= frame_i.rows_lim) ? '0 : row_cnt_q + ROW_W'(1);
      end else begin
        col_cnt_d = col_cnt_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= sample_i;
      a_x_q      <= col_cnt_q[LINE_AW-1:0];
      a_prod_q   <= prod_d;
      a_row_q    <= row_off[OUT_ROW_W-1:0];
      a_col_q    <= col_off[OUT_COL_W-1:0];
      a_last_q   <= last_d;
    end
  end

  // line buffers: read at accept, written when the word leaves stage A
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= upper_line[col_cnt_q[LINE_AW-1:0]];
    end
    if (a_adv) begin
      upper_line[a_x_q] <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_q <= middle_line[col_cnt_q[LINE_AW-1:0]];
    end
    if (a_adv) begin
      middle_line[a_x_q] <= a_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_up_q   <= '0;
      win_ctr_q  <= '0;
      win_dn_q   <= '0;
      win_left_q <= '0;
    end else if (a_adv) begin
      win_left_q <= win_ctr_q;
      win_up_q   <= top_q;
      win_ctr_q  <= mid_q;
      win_dn_q   <= a_sample_q;
    end
  end

  // window holds column x-1 (and x-2 for left); right comes from the read
  always_comb begin
    push_o            = a_adv && a_prod_q;
    push_word_o.up    = win_up_q;
    push_word_o.ctr   = win_ctr_q;
    push_word_o.dn    = win_dn_q;
    push_word_o.left  = win_left_q;
    push_word_o.right = mid_q;
    push_word_o.row   = a_row_q;
    push_word_o.col   = a_col_q;
    push_word_o.last  = a_last_q;
  end

endmodule

`default_nettype wire

FILE: hdl/hss_fifo.sv
// ---------------------------------------------------------------------------
// hss_fifo: stencil queue between front and back end
// Small register queue; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module hss_fifo import hss_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire stencil_word_t push_word_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output stencil_word_t      pop_word_o
);

  stencil_word_t entries [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_word_o = entries[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hss_back.sv
// ---------------------------------------------------------------------------
// hss_back: stencil arithmetic pipeline
// Laplacian, gain multiply, round half up, add to centre and saturate,
// with a registered output word that holds under stall.
// ---------------------------------------------------------------------------
`default_nettype none

module hss_back import hss_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [GAIN_W-1:0]    gain_i,
  input  wire logic                 fifo_valid_i,
  input  wire stencil_word_t        fifo_word_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output data_t                     new_temp_o,
  output logic [OUT_ROW_W-1:0]      out_row_o,
  output logic [OUT_COL_W-1:0]      out_col_o,
  output logic                      last_o
);

  localparam data_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                     s1_valid_q;
  logic signed [LAP_W-1:0]  s1_lap_q, s1_lap_d;
  data_t                    s1_ctr_q;
  logic [OUT_ROW_W-1:0]     s1_row_q;
  logic [OUT_COL_W-1:0]     s1_col_q;
  logic                     s1_last_q;

  logic                     s2_valid_q;
  logic signed [PROD_W-1:0] s2_prod_q, s2_prod_d;
  data_t                    s2_ctr_q;
  logic [OUT_ROW_W-1:0]     s2_row_q;
  logic [OUT_COL_W-1:0]     s2_col_q;
  logic                     s2_last_q;

  logic                     out_valid_q;
  data_t                    out_temp_q, out_temp_d;
  logic [OUT_ROW_W-1:0]     out_row_q;
  logic [OUT_COL_W-1:0]     out_col_q;
  logic                     out_last_q;

  logic s3_ready, s2_ready, s1_ready;

  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;

  assign s3_ready = !out_valid_q || !out_stall_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = fifo_valid_i && s1_ready;

  always_comb begin
    s1_lap_d = LAP_W'(fifo_word_i.up) + LAP_W'(fifo_word_i.dn)
             + LAP_W'(fifo_word_i.left) + LAP_W'(fifo_word_i.right)
             - (LAP_W'(fifo_word_i.ctr) <<< 2);
  end

  assign gain_s    = $signed({1'b0, gain_i});
  assign s2_prod_d = s1_lap_q * gain_s;

  // floor((p + half) / 2^16), then centre plus delta, clamped
  always_comb begin
    rnd     = s2_prod_q + PROD_W'(ROUND_BIAS);
    shifted = rnd >>> FRAC_SHIFT;
    sum     = SUM_W'(s2_ctr_q) + shifted[SUM_W-1:0];
    if ((&sum[SUM_W-1:DATA_WIDTH-1]) || !(|sum[SUM_W-1:DATA_WIDTH-1])) begin
      out_temp_d = sum[DATA_WIDTH-1:0];
    end else if (sum[SUM_W-1]) begin
      out_temp_d = SAT_MIN;
    end else begin
      out_temp_d = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= fifo_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_lap_q  <= s1_lap_d;
      s1_ctr_q  <= fifo_word_i.ctr;
      s1_row_q  <= fifo_word_i.row;
      s1_col_q  <= fifo_word_i.col;
      s1_last_q <= fifo_word_i.last;
    end
    if (s1_valid_q && s2_ready) begin
      s2_prod_q <= s2_prod_d;
      s2_ctr_q  <= s1_ctr_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
    if (s2_valid_q && s3_ready) begin
      out_temp_q <= out_temp_d;
      out_row_q  <= s2_row_q;
      out_col_q  <= s2_col_q;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_temp_o  = out_temp_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/heat_stencil_step.sv
// ---------------------------------------------------------------------------
// heat_stencil_step: one explicit step of the 2D heat equation
// Raster stream in, one updated interior cell out per sample whose raster row
// and column are both 2 or more; five-point stencil, Q2.30 with saturation.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  sample_i
//   out      out  out_valid_o/out_stall_i new_temp_o, out_row_o, out_col_o, last_o
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample per cycle sustained while out_stall_i is low; each line buffer does
// one read and one write per cycle. After its sample is accepted, a result passes
// the window stage, queue, laplacian, multiply and round/saturate register in order.
// Reset clears counters and pipeline valids; line buffers need no clear.
// Output stall backs up through the queue to in_stall_o.
// ---------------------------------------------------------------------------
`default_nettype none

module heat_stencil_step import hss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0] sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      new_temp_o,
  output logic [OUT_ROW_W-1:0]       out_row_o,
  output logic [OUT_COL_W-1:0]       out_col_o,
  output logic                       last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_COLS_W-1:0] cols_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [GAIN_W-1:0]     gain_q;

  logic             cfg_wr;
  logic             restart;
  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  frame_cfg_t       frame;

  logic          push;
  stencil_word_t push_word;
  logic          fifo_full;
  logic          fifo_valid;
  logic          pop;
  stencil_word_t pop_word;
  data_t         new_temp;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    restart = 1'b0;
    unique case (cfg_index_i)
      CFG_COLS: restart = cfg_wr;
      CFG_ROWS: restart = cfg_wr;
      default:  restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_COLS: cols_q <= cfg_data_i[CFG_COLS_W-1:0];
        CFG_ROWS: rows_q <= cfg_data_i[CFG_ROWS_W-1:0];
        CFG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        default:  ;
      endcase
    end
  end

  // sizes used as clamped to 1..MAX
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = ROW_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_W'(rows_q);
    end
    frame.cols_lim = cols_eff + COL_W'(1);
    frame.rows_lim = rows_eff + ROW_W'(1);
    frame.restart  = restart;
  end

  hss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (data_t'(sample_i)),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  hss_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .pop_i       (pop),
    .pop_word_o  (pop_word)
  );

  hss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .fifo_valid_i (fifo_valid),
    .fifo_word_i  (pop_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_temp_o   (new_temp),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_o       (last_o)
  );

  assign new_temp_o = new_temp;

endmodule

`default_nettype wire
